[hw/rtl/psss_pkg.sv]
package psss_pkg;

    // Sample width codes of sample_bits_mode (code 3 acts as 32 bits)
    localparam logic [1:0] MODE_W8    = 2'd0;
    localparam logic [1:0] MODE_W16   = 2'd1;
    localparam logic [1:0] MODE_W32   = 2'd2;
    localparam logic [1:0] MODE_RESET = MODE_W16;

    // Configuration register indexes
    localparam logic CFG_IDX_SAMPLE_BITS = 1'b0;
    localparam logic CFG_IDX_NORMALIZE   = 1'b1;

    // Full-scale constant of a width mode
    function automatic logic [31:0] full_scale(input logic [1:0] mode);
        logic [31:0] k;
        case (mode)
            MODE_W8:  k = 32'd127;
            MODE_W16: k = 32'd65535;
            default:  k = 32'hFFFF_FFFF;
        endcase
        return k;
    endfunction

    // Keep the low bits of the mode width, sign-extended to 32 bits
    function automatic logic [31:0] wrap_width(input logic [31:0] v, input logic [1:0] mode);
        logic [31:0] w;
        case (mode)
            MODE_W8:  w = {{24{v[7]}}, v[7:0]};
            MODE_W16: w = {{16{v[15]}}, v[15:0]};
            default:  w = v;
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/psss_div.sv]
// Restoring divider, 64-bit dividend by 32-bit divisor, two quotient bits per cycle.
// Works over the whole dividend and gives the low 32 bits of the quotient.
// The divisor must be non-zero.
module psss_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic        done_reg;
    logic [31:0] rem_reg;
    logic [63:0] quo_reg;
    logic [31:0] dvs_reg;

    logic [32:0] shift_a;
    logic [32:0] trial_a;
    logic        fit_a;
    logic [31:0] rem_a;
    logic [32:0] shift_b;
    logic [32:0] trial_b;
    logic        fit_b;
    logic [31:0] rem_b;

    // First restoring step of the cycle
    assign shift_a = {rem_reg, quo_reg[63]};
    assign trial_a = shift_a - {1'b0, dvs_reg};
    assign fit_a   = (shift_a >= {1'b0, dvs_reg});
    assign rem_a   = fit_a ? trial_a[31:0] : shift_a[31:0];

    // Second restoring step of the cycle
    assign shift_b = {rem_a, quo_reg[62]};
    assign trial_b = shift_b - {1'b0, dvs_reg};
    assign fit_b   = (shift_b >= {1'b0, dvs_reg});
    assign rem_b   = fit_b ? trial_b[31:0] : shift_b[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_b;
                quo_reg <= {quo_reg[61:0], fit_a, fit_b};
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[31:0];

endmodule

[hw/rtl/peak_scaled_signal_subtractor_core.sv]
// Channel   | Handshake             | Payload
// ----------+-----------------------+--------------------------------------------
// input     | start, busy           | main_sample, reference_sample, block_end
// result    | result_valid (strobe) | result_sample, run_end
// config    | cfg_valid, cfg_ready  | cfg_index, cfg_data
//
// Plain mode: an item gives its result in the cycle after acceptance; one item per cycle
// while busy is low. Normalized mode: items are buffered in a pair memory with no result
// until the block ends; then busy stays high while each buffered pair goes through memory
// read, 32x32 multiply, divider load, divider steps of two quotient bits and a final done step.
// Reset clears control state, loads 16-bit mode, plain mode and an empty buffer.
// Results are strobed for one cycle; the receiver cannot stall them.
module peak_scaled_signal_subtractor_core
#(
    parameter int MAX_SAMPLES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] main_sample,
    input  logic [31:0] reference_sample,
    input  logic        block_end,
    output logic        result_valid,
    output logic [31:0] result_sample,
    output logic        run_end,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_data
);

    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW = $clog2(MAX_SAMPLES + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_LOAD,
        ST_DIV
    } state_t;

    state_t      state_reg;
    logic [1:0]  mode_reg;
    logic        normalize_reg;
    logic [31:0] peak_reg;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] idx_reg;
    logic [63:0] rd_data_reg;
    logic [63:0] prod_reg;
    logic [31:0] main_hold_reg;
    logic        ref_pos_reg;
    logic        result_valid_reg;
    logic [31:0] result_sample_reg;
    logic        run_end_reg;

    // Pair memory: {main, reference}
    logic [63:0] pair_mem [MAX_SAMPLES];

    logic        accept;
    logic [31:0] fs;
    logic [31:0] m_w;
    logic [31:0] r_w;
    logic [32:0] diff;
    logic [32:0] abs_diff;
    logic [31:0] peak_base;
    logic [31:0] peak_new;
    logic [CW-1:0] fill_inc;
    logic        block_done;
    logic [31:0] rd_ref;
    logic [31:0] ref_mag;
    logic [63:0] prod_next;
    logic [31:0] acc;
    logic        last_pair;
    logic        div_done;
    logic [31:0] div_quotient;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign fs        = psss_pkg::full_scale(mode_reg);

    // Input samples at the current width, difference and its magnitude
    assign m_w      = psss_pkg::wrap_width(main_sample, mode_reg);
    assign r_w      = psss_pkg::wrap_width(reference_sample, mode_reg);
    assign diff     = {m_w[31], m_w} - {r_w[31], r_w};
    assign abs_diff = diff[32] ? (33'd0 - diff) : diff;

    // Running peak, restarted at the first pair of a block
    assign peak_base  = (fill_reg == '0) ? fs : peak_reg;
    assign peak_new   = (abs_diff[31:0] > peak_base) ? abs_diff[31:0] : peak_base;
    assign fill_inc   = fill_reg + CW'(1);
    assign block_done = block_end || (fill_inc == CW'(MAX_SAMPLES));

    // Scaling product of the read reference magnitude
    assign rd_ref    = rd_data_reg[31:0];
    assign ref_mag   = rd_ref[31] ? (32'd0 - rd_ref) : rd_ref;
    assign prod_next = ref_mag * fs;

    // Removal of the scaled reference
    assign acc       = ref_pos_reg ? (main_hold_reg - div_quotient)
                                   : (main_hold_reg + div_quotient);
    assign last_pair = ((idx_reg + CW'(1)) == fill_reg);

    psss_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_LOAD),
        .dividend (prod_reg),
        .divisor  (peak_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Memory write on buffered items, registered read during emission
    always_ff @(posedge clk)
    begin
        if (accept && normalize_reg)
        begin
            pair_mem[fill_reg[AW-1:0]] <= {m_w, r_w};
        end
        if (state_reg == ST_READ)
        begin
            rd_data_reg <= pair_mem[idx_reg[AW-1:0]];
        end
    end

    // Control, configuration and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            mode_reg          <= psss_pkg::MODE_RESET;
            normalize_reg     <= 1'b0;
            peak_reg          <= psss_pkg::full_scale(psss_pkg::MODE_RESET);
            fill_reg          <= '0;
            idx_reg           <= '0;
            prod_reg          <= '0;
            main_hold_reg     <= '0;
            ref_pos_reg       <= 1'b0;
            result_valid_reg  <= 1'b0;
            result_sample_reg <= '0;
            run_end_reg       <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;

            // Configuration writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    psss_pkg::CFG_IDX_SAMPLE_BITS: mode_reg      <= cfg_data;
                    psss_pkg::CFG_IDX_NORMALIZE:   normalize_reg <= cfg_data[0];
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && !normalize_reg)
                    begin
                        result_valid_reg  <= 1'b1;
                        result_sample_reg <= psss_pkg::wrap_width(diff[31:0], mode_reg);
                        run_end_reg       <= block_end;
                    end
                    else if (accept)
                    begin
                        peak_reg <= peak_new;
                        fill_reg <= fill_inc;
                        if (block_done)
                        begin
                            idx_reg   <= '0;
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    prod_reg      <= prod_next;
                    main_hold_reg <= rd_data_reg[63:32];
                    ref_pos_reg   <= !rd_ref[31];
                    state_reg     <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        result_valid_reg  <= 1'b1;
                        result_sample_reg <= psss_pkg::wrap_width(acc, mode_reg);
                        run_end_reg       <= last_pair;
                        idx_reg           <= idx_reg + CW'(1);
                        if (last_pair)
                        begin
                            fill_reg  <= '0;
                            peak_reg  <= fs;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid  = result_valid_reg;
    assign result_sample = result_sample_reg;
    assign run_end       = run_end_reg;

    // A plain item gives its result in the next cycle
    a_plain_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !normalize_reg) |=> result_valid)
        else $error("plain item without result");

    // Every result comes from the plain path or a finished division
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ($past(state_reg == ST_DIV && div_done)
                          || $past(accept && !normalize_reg)))
        else $error("result without a source");

    // The divider finishes only while emission waits for it
    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider done outside division state");

    // Buffer never overfills
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(MAX_SAMPLES))
        else $error("fill count beyond buffer depth");

endmodule

[tb/peak_scaled_signal_subtractor_core_test.sv]
`timescale 1ns / 1ps

module peak_scaled_signal_subtractor_core_test;

    localparam int BUF_DEPTH     = 64;
    localparam int RANDOM_ITEMS  = 108;
    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_LIMIT   = 1000;

    typedef struct packed {
        logic [31:0] sample;
        logic        last;
    } sample_out_t;

    typedef enum logic {ROW_PAIR, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [31:0] main_v;
        logic [31:0] ref_v;
        logic        end_v;
        logic        reg_idx;
        logic [1:0]  reg_val;
        logic        pinned;
        sample_out_t want;
    } stim_row_t;

    // Block ports, all known from time zero
    logic        clk;
    logic        rst_n            = 1'b0;
    logic        start            = 1'b0;
    logic        busy;
    logic [31:0] main_sample      = '0;
    logic [31:0] reference_sample = '0;
    logic        block_end        = 1'b0;
    logic        result_valid;
    logic [31:0] result_sample;
    logic        run_end;
    logic        cfg_valid        = 1'b0;
    logic        cfg_ready;
    logic        cfg_index        = 1'b0;
    logic [1:0]  cfg_data         = '0;

    // Typed result that travels with a directed item
    logic        pin_pair   = 1'b0;
    sample_out_t pin_output = '0;

    // Mirror of the block's state
    logic [1:0]        width_mode  = psss_pkg::MODE_RESET;
    logic              norm_on     = 1'b0;
    logic signed [31:0] main_buf [BUF_DEPTH];
    logic signed [31:0] ref_buf  [BUF_DEPTH];
    longint unsigned   peak_level  = 65535;
    int unsigned       fill_level  = 0;

    sample_out_t due_samples[$];
    stim_row_t   directed_rows[$];

    int mismatches     = 0;
    int results_seen   = 0;
    int reg_writes     = 0;
    int blocks_emitted = 0;
    int full_blocks    = 0;
    int quiet_cycles   = 0;
    int idle_pct       = 27;

    peak_scaled_signal_subtractor_core DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .main_sample      (main_sample),
        .reference_sample (reference_sample),
        .block_end        (block_end),
        .result_valid     (result_valid),
        .result_sample    (result_sample),
        .run_end          (run_end),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int width_bits(input logic [1:0] mode);
        case (mode)
            psss_pkg::MODE_W8:  return 8;
            psss_pkg::MODE_W16: return 16;
            default:            return 32;
        endcase
    endfunction

    function automatic longint unsigned full_scale_of(input logic [1:0] mode);
        case (mode)
            psss_pkg::MODE_W8:  return 127;
            psss_pkg::MODE_W16: return 65535;
            default:            return 64'hFFFF_FFFF;
        endcase
    endfunction

    // Low bits of the sample width, sign-extended to 32
    function automatic logic [31:0] fold_to_width(input logic [31:0] v, input logic [1:0] mode);
        int unsigned        sh;
        logic signed [31:0] t;
        sh = 32 - width_bits(mode);
        t  = v << sh;
        return t >>> sh;
    endfunction

    // Apply one accepted pair: plain difference, or buffer and emit the scaled block
    function automatic void subtract_pair(input logic [31:0] main_in,
                                          input logic [31:0] ref_in,
                                          input logic end_in);
        logic signed [31:0] m;
        logic signed [31:0] r;
        longint             mv;
        longint             rv;
        longint             diff;
        longint             mag_d;
        longint unsigned    k;
        longint unsigned    mag;
        longint unsigned    q;
        logic [63:0]        acc;
        sample_out_t        out;
        int                 n;
        m    = fold_to_width(main_in, width_mode);
        r    = fold_to_width(ref_in, width_mode);
        mv   = m;
        rv   = r;
        diff = mv - rv;
        if (!norm_on)
        begin
            out.sample = fold_to_width(diff[31:0], width_mode);
            out.last   = end_in;
            due_samples.push_back(out);
            return;
        end
        // first pair of a block reloads the peak
        if (fill_level == 0)
            peak_level = full_scale_of(width_mode);
        mag_d = (diff < 0) ? -diff : diff;
        if (mag_d > peak_level)
            peak_level = mag_d;
        main_buf[fill_level] = m;
        ref_buf[fill_level]  = r;
        fill_level++;
        if (!end_in && fill_level < BUF_DEPTH)
            return;
        if (!end_in)
            full_blocks++;
        // scale and wrap at the width in force now
        k = full_scale_of(width_mode);
        n = fill_level;
        for (int i = 0; i < n; i++)
        begin
            mv  = main_buf[i];
            rv  = ref_buf[i];
            mag = (rv < 0) ? -rv : rv;
            q   = mag * k / peak_level;
            acc = mv;
            acc = (rv > 0) ? acc - q : acc + q;
            out.sample = fold_to_width(acc[31:0], width_mode);
            out.last   = (i == n - 1);
            due_samples.push_back(out);
        end
        fill_level = 0;
        peak_level = full_scale_of(width_mode);
        blocks_emitted++;
    endfunction

    function automatic void compare_output(input logic [31:0] got_sample, input logic got_last);
        sample_out_t want;
        results_seen++;
        if (due_samples.size() == 0)
        begin
            $display("%0t: unexpected result: expected none, actual %h run_end %b",
                     $time, got_sample, got_last);
            mismatches++;
            return;
        end
        want = due_samples.pop_front();
        if (got_sample !== want.sample)
        begin
            $display("%0t: result_sample expected %h, actual %h", $time, want.sample, got_sample);
            mismatches++;
        end
        if (got_last !== want.last)
        begin
            $display("%0t: run_end expected %b, actual %b", $time, want.last, got_last);
            mismatches++;
        end
    endfunction

    // Sample all three channels at the clock edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                compare_output(result_sample, run_end);
            if (cfg_valid && cfg_ready)
            begin
                reg_writes++;
                if (cfg_index == psss_pkg::CFG_IDX_SAMPLE_BITS)
                    width_mode = cfg_data;
                else
                    norm_on = cfg_data[0];
            end
            if (start && !busy)
            begin
                subtract_pair(main_sample, reference_sample, block_end);
                if (pin_pair)
                    due_samples[due_samples.size() - 1] = pin_output;
            end
            if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // Watchdog: too long with no traffic on any channel
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

    function automatic stim_row_t pair_row(input logic [31:0] m, input logic [31:0] r,
                                           input logic e);
        return '{ROW_PAIR, m, r, e, 1'b0, 2'd0, 1'b0, '0};
    endfunction

    function automatic stim_row_t pinned_row(input logic [31:0] m, input logic [31:0] r,
                                             input logic e, input logic [31:0] s,
                                             input logic l);
        return '{ROW_PAIR, m, r, e, 1'b0, 2'd0, 1'b1, {s, l}};
    endfunction

    function automatic stim_row_t reg_row(input logic idx, input logic [1:0] val);
        return '{ROW_REG, 32'd0, 32'd0, 1'b0, idx, val, 1'b0, '0};
    endfunction

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 15))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'h0000_007F;
            5:       return 32'hFFFF_8000;
            default: return $urandom;
        endcase
    endfunction

    // Offer one item, hold it until taken, then maybe idle
    task automatic send_pair(input logic [31:0] m, input logic [31:0] r, input logic e,
                             input logic pin, input sample_out_t want);
        start            <= 1'b1;
        main_sample      <= m;
        reference_sample <= r;
        block_end        <= e;
        pin_pair         <= pin;
        pin_output       <= want;
        do
            @(posedge clk);
        while (busy);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Stop sending, wait for every due result, then let the block finish its work
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (due_samples.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [1:0] val);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int          directed_sent;
        int          random_sent;
        int          seg_len;
        int          reg_pick;
        logic        norm_plan;
        logic        close_block;
        logic        full_done;
        logic        e;
        logic [1:0]  val;
        stim_row_t   row;

        directed_sent = 0;
        random_sent   = 0;
        full_done     = 1'b0;

        // Plain subtraction at the reset width, then each width's wrap
        directed_rows.push_back(pinned_row(32'h0000_0005, 32'h0000_0003, 1'b1,
                                           32'h0000_0002, 1'b1));
        directed_rows.push_back(pinned_row(32'h0000_7FFF, 32'h0000_8000, 1'b0,
                                           32'hFFFF_FFFF, 1'b0));
        directed_rows.push_back(pinned_row(32'hFFFF_8000, 32'h0000_0001, 1'b1,
                                           32'h0000_7FFF, 1'b1));
        directed_rows.push_back(pinned_row(32'hABCD_0010, 32'h1234_0004, 1'b0,
                                           32'h0000_000C, 1'b0));
        directed_rows.push_back(reg_row(psss_pkg::CFG_IDX_SAMPLE_BITS, psss_pkg::MODE_W8));
        directed_rows.push_back(pinned_row(32'h0000_007F, 32'hFFFF_FF80, 1'b1,
                                           32'hFFFF_FFFF, 1'b1));
        directed_rows.push_back(pinned_row(32'h0000_0080, 32'h0000_0001, 1'b0,
                                           32'h0000_007F, 1'b0));
        directed_rows.push_back(reg_row(psss_pkg::CFG_IDX_SAMPLE_BITS, psss_pkg::MODE_W32));
        directed_rows.push_back(pinned_row(32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
                                           32'hFFFF_FFFF, 1'b1));
        directed_rows.push_back(pinned_row(32'h8000_0000, 32'h0000_0001, 1'b0,
                                           32'h7FFF_FFFF, 1'b0));
        // unused width code acts as 32 bits
        directed_rows.push_back(reg_row(psss_pkg::CFG_IDX_SAMPLE_BITS, 2'd3));
        directed_rows.push_back(pinned_row(32'h0001_0000, 32'h0000_0000, 1'b1,
                                           32'h0001_0000, 1'b1));
        directed_rows.push_back(pinned_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0,
                                           32'h0000_0000, 1'b0));
        // Normalised 8-bit block with the peak above full scale
        directed_rows.push_back(reg_row(psss_pkg::CFG_IDX_SAMPLE_BITS, psss_pkg::MODE_W8));
        directed_rows.push_back(reg_row(psss_pkg::CFG_IDX_NORMALIZE, 2'd1));
        directed_rows.push_back(pair_row(32'h0000_000A, 32'h0000_0014, 1'b0));
        directed_rows.push_back(pair_row(32'h0000_007F, 32'h0000_0080, 1'b0));
        directed_rows.push_back(pair_row(32'h0000_0080, 32'h0000_007F, 1'b1));
        // next block starts again from full scale
        directed_rows.push_back(pair_row(32'h0000_0003, 32'h0000_0064, 1'b1));
        // width widened for a new block, then narrowed while it is part full
        directed_rows.push_back(reg_row(psss_pkg::CFG_IDX_SAMPLE_BITS, psss_pkg::MODE_W16));
        directed_rows.push_back(pair_row(32'h0000_7FFF, 32'hFFFF_8000, 1'b0));
        directed_rows.push_back(pair_row(32'h0000_1234, 32'h0000_0100, 1'b0));
        directed_rows.push_back(reg_row(psss_pkg::CFG_IDX_SAMPLE_BITS, psss_pkg::MODE_W8));
        directed_rows.push_back(pair_row(32'h0000_0040, 32'hFFFF_FFC0, 1'b1));
        // normalisation off mid-block; buffered pairs wait for the next block end
        directed_rows.push_back(reg_row(psss_pkg::CFG_IDX_SAMPLE_BITS, psss_pkg::MODE_W32));
        directed_rows.push_back(pair_row(32'h4000_0000, 32'hC000_0000, 1'b0));
        directed_rows.push_back(pair_row(32'h1234_5678, 32'h8765_4321, 1'b0));
        directed_rows.push_back(reg_row(psss_pkg::CFG_IDX_NORMALIZE, 2'd0));
        directed_rows.push_back(pinned_row(32'h0000_0009, 32'h0000_0004, 1'b1,
                                           32'h0000_0005, 1'b1));
        directed_rows.push_back(reg_row(psss_pkg::CFG_IDX_NORMALIZE, 2'd1));
        directed_rows.push_back(pair_row(32'hFFFF_FFFF, 32'h0000_0000, 1'b1));
        // upper data bit ignored by the enable register
        directed_rows.push_back(reg_row(psss_pkg::CFG_IDX_NORMALIZE, 2'd2));
        directed_rows.push_back(pinned_row(32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
                                           32'h0000_0001, 1'b1));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_REG)
                write_reg(row.reg_idx, row.reg_val);
            else
            begin
                send_pair(row.main_v, row.ref_v, row.end_v, row.pinned, row.want);
                directed_sent++;
            end
        end

        // Random segments: new settings, then a block (or a run of plain items)
        while (random_sent < RANDOM_ITEMS)
        begin
            reg_pick = $urandom_range(0, 3);
            if (!full_done && random_sent >= 20)
            begin
                // one block long enough to fill the buffer
                write_reg(psss_pkg::CFG_IDX_NORMALIZE, 2'd1);
                norm_plan   = 1'b1;
                seg_len     = BUF_DEPTH;
                close_block = 1'b0;
                full_done   = 1'b1;
            end
            else
            begin
                if (reg_pick != 0)
                begin
                    val = 2'($urandom_range(0, 3));
                    write_reg(psss_pkg::CFG_IDX_SAMPLE_BITS, val);
                end
                if (reg_pick != 1)
                begin
                    val       = 2'($urandom_range(0, 3));
                    norm_plan = val[0];
                    write_reg(psss_pkg::CFG_IDX_NORMALIZE, val);
                end
                else
                    norm_plan = norm_on;
                // mostly short blocks; some left open to be finished later
                if (norm_plan)
                    seg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40)
                                                          : $urandom_range(1, 6);
                else
                    seg_len = $urandom_range(1, 8);
                if (seg_len > RANDOM_ITEMS - random_sent)
                    seg_len = RANDOM_ITEMS - random_sent;
                close_block = ($urandom_range(0, 5) != 0);
            end
            for (int i = 0; i < seg_len; i++)
            begin
                if (norm_plan)
                    e = close_block && (i == seg_len - 1);
                else
                    e = 1'($urandom_range(0, 1));
                idle_pct = (random_sent < RANDOM_ITEMS / 3)     ? 27 :
                           (random_sent < 2 * RANDOM_ITEMS / 3) ? 51 : 0;
                send_pair(pick_sample(), pick_sample(), e, 1'b0, '0);
                random_sent++;
            end
        end

        drain_results();
        $display("Run covered %0d directed and %0d random items, %0d results, %0d register writes",
                 directed_sent, random_sent, results_seen, reg_writes);
        $display("Normalised blocks emitted: %0d, of which %0d ended by a full buffer",
                 blocks_emitted, full_blocks);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
